FILE: design/ffba_pkg.sv
package ffba_pkg;

	localparam int NUM_BLOCKS  = 1024;
	localparam int BLOCK_BYTES = 32;
	localparam int ADDR_W      = 10;
	localparam int LEN_W       = 11;
	localparam int POS_W       = 12;
	localparam int BYTE_SHIFT  = 5;
	localparam int WORD_W      = LEN_W + 1;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_OOM     = 2'd1,
		STAT_BAD_HDL = 2'd2
	} status_t;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic             too_big;
		logic [LEN_W-1:0] need;
	} need_t;

endpackage

FILE: design/ffba_ram.sv
module ffba_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/ffba_need.sv
module ffba_need (
	input  logic           clk,
	input  logic           load,
	input  logic [31:0]    elem_count,
	input  logic [31:0]    elem_size,
	output ffba_pkg::need_t need
);
	import ffba_pkg::*;

	logic [63:0]      bytes_s1;
	need_t            need_s2;
	logic [LEN_W-1:0] quot;
	logic [LEN_W:0]   blocks;

	always_comb begin
		quot   = {1'b0, bytes_s1[BYTE_SHIFT+ADDR_W-1:BYTE_SHIFT]}
			+ {{(LEN_W-1){1'b0}}, |bytes_s1[BYTE_SHIFT-1:0]};
		blocks = {1'b0, quot} + {{LEN_W{1'b0}}, 1'b1};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s1 <= elem_count * elem_size;
		end
		need_s2.too_big <= (|bytes_s1[63:BYTE_SHIFT+ADDR_W])
			|| (blocks > (LEN_W+1)'(NUM_BLOCKS));
		need_s2.need    <= blocks[LEN_W-1:0];
	end

	assign need = need_s2;

endmodule

FILE: design/first_fit_block_allocator_top.sv
// First-fit block allocator over an arena of 1024 blocks of 32 bytes.
// Input channel: command, elem_count, elem_size and handle, with in_valid and
// in_stall. A beat is taken when in_valid is high and in_stall is low.
// Output channel: status, alloc_handle and bytes_used, with out_valid and
// out_stall. Every input beat yields exactly one output beat.
// An allocate walks the segment chain from block 0 and takes the first free
// segment that fits, splitting off the remainder. A free walks the chain to
// find the segment and its predecessor, then merges with free neighbors.
// The segment table sits in one single-port-write RAM with registered reads,
// and the walk reads each segment in S_RD and evaluates it in S_EV.
// Only one request is in flight; in_stall stays high until its result is
// loaded into the output register.
// After reset the table is cleared one entry a cycle while in_stall is high;
// the arena then is one free segment and the internal byte count is 0.
// A stalled result stays in the output register; the next request may
// already be taken and worked on, and waits to finish until it is taken.
module first_fit_block_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [31:0] elem_count,
	input  logic [31:0] elem_size,
	input  logic [10:0] handle,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [10:0] alloc_handle,
	output logic [15:0] bytes_used
);
	import ffba_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_MUL, S_NEED, S_RD, S_EV, S_A_SPLIT, S_A_HEAD,
		S_F_NRD, S_F_NEV, S_F_PREV, S_F_TGT, S_DONE
	} state_t;

	state_t           state_q;
	logic [ADDR_W:0]  clr_q;
	logic             cmd_q;
	logic [LEN_W-1:0] target_q;
	logic [POS_W-1:0] pos_q;
	logic [ADDR_W-1:0] prev_q;
	logic [LEN_W-1:0] prev_len_q;
	logic             prev_free_q;
	logic             has_prev_q;
	logic [LEN_W-1:0] cur_len_q;
	logic [POS_W-1:0] nxt_q;
	logic [15:0]      bytes_q;
	status_t          res_status_q;
	logic [LEN_W-1:0] res_handle_q;
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [LEN_W-1:0] handle_out_q;
	logic [15:0]      bytes_out_q;

	need_t            need;
	logic             we;
	logic [ADDR_W-1:0] waddr;
	logic [WORD_W-1:0] wdata;
	logic [ADDR_W-1:0] raddr;
	logic [WORD_W-1:0] rdata;
	logic             rd_free;
	logic [LEN_W-1:0] rd_len;
	logic [POS_W-1:0] pos_next;
	logic             accept;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign rd_free  = rdata[WORD_W-1];
	assign rd_len   = rdata[LEN_W-1:0];
	assign pos_next = pos_q + {1'b0, rd_len};

	ffba_need u_need (
		.clk        (clk),
		.load       (accept),
		.elem_count (elem_count),
		.elem_size  (elem_size),
		.need       (need)
	);

	ffba_ram #(.WIDTH(WORD_W), .DEPTH(NUM_BLOCKS)) u_seg_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		we    = 1'b0;
		waddr = pos_q[ADDR_W-1:0];
		wdata = '0;
		raddr = pos_q[ADDR_W-1:0];
		unique case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q[ADDR_W-1:0];
				wdata = (clr_q == '0) ? {1'b1, LEN_W'(NUM_BLOCKS)} : {1'b1, {LEN_W{1'b0}}};
			end
			S_A_SPLIT: begin
				we    = (cur_len_q > need.need);
				waddr = pos_q[ADDR_W-1:0] + need.need[ADDR_W-1:0];
				wdata = {1'b1, cur_len_q - need.need};
			end
			S_A_HEAD: begin
				we    = 1'b1;
				wdata = {1'b0, need.need};
			end
			S_F_NRD: begin
				raddr = nxt_q[ADDR_W-1:0];
			end
			S_F_NEV: begin
				we    = (rd_len != '0) && rd_free;
				waddr = nxt_q[ADDR_W-1:0];
				wdata = {1'b1, {LEN_W{1'b0}}};
			end
			S_F_PREV: begin
				we    = 1'b1;
				waddr = prev_q;
				wdata = {1'b1, prev_len_q + cur_len_q};
			end
			S_F_TGT: begin
				we    = 1'b1;
				waddr = target_q[ADDR_W-1:0];
				wdata = (has_prev_q && prev_free_q) ? {1'b1, {LEN_W{1'b0}}}
					: {1'b1, cur_len_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			bytes_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (ADDR_W+1)'(NUM_BLOCKS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						cmd_q      <= command;
						target_q   <= handle - 1'b1;
						pos_q      <= '0;
						has_prev_q <= 1'b0;
						res_handle_q <= '0;
						if (command == CMD_ALLOC) begin
							state_q <= S_MUL;
						end else if (handle == '0) begin
							res_status_q <= STAT_OK;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_MUL: state_q <= S_NEED;
				S_NEED: state_q <= S_RD;
				S_RD: state_q <= S_EV;
				S_EV: begin
					if (rd_len == '0) begin
						res_status_q <= (cmd_q == CMD_ALLOC) ? STAT_OOM : STAT_BAD_HDL;
						state_q      <= S_DONE;
					end else if (cmd_q == CMD_ALLOC && rd_free && !need.too_big
							&& rd_len >= need.need) begin
						cur_len_q <= rd_len;
						state_q   <= S_A_SPLIT;
					end else if (cmd_q == CMD_FREE
							&& pos_q == {1'b0, target_q}) begin
						if (rd_free) begin
							res_status_q <= STAT_BAD_HDL;
							state_q      <= S_DONE;
						end else begin
							cur_len_q <= rd_len;
							nxt_q     <= pos_q + {1'b0, rd_len};
							bytes_q   <= bytes_q - {rd_len, {BYTE_SHIFT{1'b0}}};
							state_q   <= S_F_NRD;
						end
					end else begin
						prev_q      <= pos_q[ADDR_W-1:0];
						prev_len_q  <= rd_len;
						prev_free_q <= rd_free;
						has_prev_q  <= 1'b1;
						pos_q       <= pos_next;
						if (pos_next >= POS_W'(NUM_BLOCKS)) begin
							res_status_q <= (cmd_q == CMD_ALLOC) ? STAT_OOM : STAT_BAD_HDL;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_A_SPLIT: state_q <= S_A_HEAD;
				S_A_HEAD: begin
					bytes_q      <= bytes_q + {need.need, {BYTE_SHIFT{1'b0}}};
					res_status_q <= STAT_OK;
					res_handle_q <= pos_q[LEN_W-1:0] + 1'b1;
					state_q      <= S_DONE;
				end
				S_F_NRD: begin
					if (nxt_q >= POS_W'(NUM_BLOCKS)) begin
						state_q <= (has_prev_q && prev_free_q) ? S_F_PREV : S_F_TGT;
					end else begin
						state_q <= S_F_NEV;
					end
				end
				S_F_NEV: begin
					if (rd_len != '0 && rd_free) begin
						cur_len_q <= cur_len_q + rd_len;
					end
					state_q <= (has_prev_q && prev_free_q) ? S_F_PREV : S_F_TGT;
				end
				S_F_PREV: state_q <= S_F_TGT;
				S_F_TGT: begin
					res_status_q <= STAT_OK;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						status_q     <= res_status_q;
						handle_out_q <= res_handle_q;
						bytes_out_q  <= bytes_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign alloc_handle = handle_out_q;
	assign bytes_used   = bytes_out_q;

`ifndef ASSERT_OFF
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE) && (state_q != S_CLEAR))
		else $error("request accepted without starting work");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(status_q))
		else $error("stalled result lost");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (status_q != 2'd3))
		else $error("undefined status code");
	a_bytes_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> bytes_q <= 16'(NUM_BLOCKS * BLOCK_BYTES))
		else $error("byte count beyond arena");
`endif

endmodule
